>>> src/rct_pkg.sv
// Shared widths and controller/datapath handshake types for the run count tracker.
package rct_pkg;

  localparam int unsigned LenW   = 11;
  localparam int unsigned PosW   = 10;
  localparam int unsigned CountW = 11;

  typedef struct packed {
    logic clr_wr;      // write zero at the clear pointer, advance it
    logic cap_item;    // accept beat: latch item, read left and old value
    logic rd_right;    // latch left/old data, read right neighbour
    logic commit;      // write value, update count, load result
    logic sweep_init;  // restart recount
    logic sweep_step;  // read next neighbour pair of the recount
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;    // clear pointer at last entry
    logic sweep_more;  // recount has another pair to read
    logic out_free;    // result register can take a new beat
  } dp_status_t;

endpackage

>>> src/rct_in_if.sv
// Input channel: one write beat (position, value).
interface rct_in_if #(
  parameter int unsigned VALUE_BITS = 32
);
  import rct_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PosW-1:0]       position;
  logic [VALUE_BITS-1:0] new_value;

  modport source (output valid, output position, output new_value, input ready);
  modport sink   (input valid, input position, input new_value, output ready);
endinterface

>>> src/rct_out_if.sv
// Output channel: one result beat (run count, position error).
interface rct_out_if;
  import rct_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] run_count;
  logic              position_error;

  modport source (output valid, output run_count, output position_error, input ready);
  modport sink   (input valid, input run_count, input position_error, output ready);
endinterface

>>> src/rct_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module rct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/rct_ctrl.sv
// Controller: clearing pass, recount sweep and the three-step update sequence.
module rct_ctrl import rct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_INIT   = 3'd4;
  localparam logic [2:0] S_SWEEP  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       pend_q, pend_d;

  // length writes may land at any time; a pending one restarts the recount
  assign pend_d     = cfg_we_i | (pend_q & (state_q != S_INIT));
  assign in_ready_o = (state_q == S_IDLE) & ~pend_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pend_q) begin
          state_d = S_INIT;
        end else if (in_valid_i) begin
          cmd_o.cap_item = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_right = 1'b1;
        state_d        = S_UPDATE;
      end
      S_UPDATE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_INIT: begin
        cmd_o.sweep_init = 1'b1;
        state_d          = S_SWEEP;
      end
      S_SWEEP: begin
        if (pend_q) begin
          state_d = S_INIT;
        end else begin
          cmd_o.sweep_step = 1'b1;
          if (!status_i.sweep_more) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule

>>> src/rct_dp.sv
// Datapath: value memory, length register, run counter, compare logic, result register.
module rct_dp import rct_pkg::*; #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LenW-1:0]       cfg_data_i,
  input  logic [PosW-1:0]       in_position_i,
  input  logic [VALUE_BITS-1:0] in_new_value_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [CountW-1:0]     out_run_count_o,
  output logic                  out_position_error_o
);

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned LenMax  = (1 << LenW) - 1;
  localparam int unsigned MaxLen  = (DEPTH < LenMax) ? DEPTH : LenMax;
  localparam logic [LenW-1:0] MaxLenV  = LenW'(MaxLen);
  localparam logic [AW-1:0]   LastAddr = AW'(DEPTH - 1);

  logic [LenW-1:0]       len_q, len_eff;
  logic [AW-1:0]         clr_idx_q;
  logic [LenW-1:0]       sweep_idx_q, sweep_next;
  logic                  cmp_valid_q;
  logic [CountW-1:0]     runs_q, runs_d, runs_upd;
  logic [PosW-1:0]       pos_q;
  logic [VALUE_BITS-1:0] val_q, left_q, old_q;
  logic                  err_q, in_err;
  logic                  out_valid_q;
  logic [CountW-1:0]     out_count_q;
  logic                  out_err_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] ram_wdata, rdata_a, rdata_b;

  logic [LenW-1:0]       pos_next;
  logic                  left_ok, right_ok;
  logic                  old_l, new_l, old_r, new_r;
  logic [1:0]            n_inc, n_dec;

  // zero length acts as one, oversize acts as the full store
  always_comb begin
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_q > MaxLenV) begin
      len_eff = MaxLenV;
    end else begin
      len_eff = len_q;
    end
  end

  assign in_err     = LenW'(in_position_i) >= len_eff;
  assign sweep_next = sweep_idx_q + LenW'(1);
  assign pos_next   = LenW'(pos_q) + LenW'(1);
  assign left_ok    = pos_q != '0;
  assign right_ok   = pos_next < len_eff;

  assign status_o.clr_last   = clr_idx_q == LastAddr;
  assign status_o.sweep_more = sweep_next < len_eff;
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

  // read port A: left, then right neighbour; port B: old value
  always_comb begin
    raddr_a = AW'(pos_next);
    raddr_b = AW'(pos_q);
    if (cmd_i.cap_item) begin
      raddr_a = AW'(in_position_i) - AW'(1);
      raddr_b = AW'(in_position_i);
    end else if (cmd_i.sweep_step) begin
      raddr_a = AW'(sweep_idx_q);
      raddr_b = AW'(sweep_next);
    end
  end

  assign ram_we    = cmd_i.clr_wr | (cmd_i.commit & ~err_q);
  assign ram_waddr = cmd_i.clr_wr ? clr_idx_q : AW'(pos_q);
  assign ram_wdata = cmd_i.clr_wr ? '0 : val_q;

  rct_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // pair bits inside the length always match the store, so old equality
  // is recomputed from the old value
  assign old_l = left_ok  & (left_q  == old_q);
  assign new_l = left_ok  & (left_q  == val_q);
  assign old_r = right_ok & (rdata_a == old_q);
  assign new_r = right_ok & (rdata_a == val_q);
  assign n_inc = {1'b0, old_l & ~new_l} + {1'b0, old_r & ~new_r};
  assign n_dec = {1'b0, ~old_l & new_l} + {1'b0, ~old_r & new_r};
  assign runs_upd = runs_q + CountW'(n_inc) - CountW'(n_dec);

  always_comb begin
    runs_d = runs_q;
    priority if (cmd_i.sweep_init) begin
      runs_d = CountW'(1);
    end else if (cmd_i.commit && !err_q) begin
      runs_d = runs_upd;
    end else if (cmp_valid_q && (rdata_a != rdata_b)) begin
      runs_d = runs_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= MaxLenV;
      clr_idx_q   <= '0;
      sweep_idx_q <= '0;
      cmp_valid_q <= 1'b0;
      runs_q      <= CountW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      if (cmd_i.clr_wr) begin
        clr_idx_q <= clr_idx_q + AW'(1);
      end
      if (cmd_i.sweep_init) begin
        sweep_idx_q <= '0;
      end else if (cmd_i.sweep_step && status_o.sweep_more) begin
        sweep_idx_q <= sweep_next;
      end
      cmp_valid_q <= cmd_i.sweep_step & status_o.sweep_more;
      runs_q      <= runs_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      pos_q <= in_position_i;
      val_q <= in_new_value_i;
      err_q <= in_err;
    end
    if (cmd_i.rd_right) begin
      left_q <= rdata_a;
      old_q  <= rdata_b;
    end
    if (cmd_i.commit) begin
      out_count_q <= runs_d;
      out_err_q   <= err_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_run_count_o      = out_count_q;
  assign out_position_error_o = out_err_q;

endmodule

>>> src/run_count_tracker_unit.sv
// Run count tracker: counts runs of equal neighbours under single-element writes.
//
// Input channel in_i carries (position, new_value) write beats; output channel
// out_o returns one (run_count, position_error) beat per input beat, in order.
// An out-of-range position is flagged and leaves the store and count unchanged.
// cfg_we_i/cfg_data_i write length_in_use; a write starts a recount sweep over the
// first length_in_use entries, one neighbour pair per cycle, restarted by a
// further write; in_i.ready stays low until it ends (zero counts as one, oversize
// as DEPTH). Result valid rises as the update step commits, after the read step;
// a new beat is taken only once the last has committed: the value memory has two
// read ports and the update needs three reads (left, old, right) before the store
// write. Reset: the store is cleared by a pass over all DEPTH entries, one entry
// per cycle, with in_i.ready low; the run count starts at 1, the length at DEPTH.
// Output stall: the result register holds its beat; one more input beat is
// accepted and waits in its update step until the result register frees.
module run_count_tracker_unit import rct_pkg::*; #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_data_i,
  rct_in_if.sink          in_i,
  rct_out_if.source       out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rct_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_data_i           (cfg_data_i),
    .in_position_i        (in_i.position),
    .in_new_value_i       (in_i.new_value),
    .cmd_i                (cmd),
    .status_o             (status),
    .out_ready_i          (out_o.ready),
    .out_valid_o          (out_o.valid),
    .out_run_count_o      (out_o.run_count),
    .out_position_error_o (out_o.position_error)
  );

endmodule
